@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers, all checks are off while reset is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent starting in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error(msg);

// condition never holds
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

@@ design/ops_pkg.sv @@
// ----------------------------------------------------------------------------
// ops_pkg
// shared constants and types of the operator priority scheduler
// ----------------------------------------------------------------------------
package ops_pkg;

    localparam int NUM_OPS    = 8;
    localparam int NUM_PIPES  = 4;
    localparam int CYCLE_BITS = 32;

    localparam int OP_IDX_W   = (NUM_OPS > 1) ? $clog2(NUM_OPS) : 1;
    localparam int PIPE_IDX_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;

    localparam int SLOT_W     = 3;
    localparam int PMAP_W     = 2;
    localparam int TOT_W      = 3;
    localparam int MULT_W     = TOT_W + 1;
    localparam int MCNT_W     = $clog2(MULT_W);
    localparam int LEFT_W     = 32;
    localparam int PRIO_W     = 35;
    localparam int ADJ_W      = 64;
    localparam int TOTALS_W   = 24;
    localparam int PMAP_REG_W = 16;
    localparam int MASK_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    localparam int ALU_W = (CYCLE_BITS > PRIO_W) ? CYCLE_BITS : PRIO_W;
    localparam int SAT_W = (CYCLE_BITS > LEFT_W) ? CYCLE_BITS : LEFT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ADJ    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTALS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PMAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 3'd4;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_NOTIFY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_ADV,
        S_SUB,
        S_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             carry;
        logic             zero;
    } t_alu_rsp;

endpackage

@@ design/ops_alu.sv @@
// ----------------------------------------------------------------------------
// ops_alu
// shared add and subtract unit with carry and zero flags
// ----------------------------------------------------------------------------
module ops_alu
    import ops_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_W-1:0] w_b;
    logic [ALU_W:0]   w_full;

    assign w_b    = i_req.sub ? ~i_req.b : i_req.b;
    assign w_full = {1'b0, i_req.a} + {1'b0, w_b} + (ALU_W + 1)'(i_req.sub);

    assign o_rsp.sum   = w_full[ALU_W-1:0];
    assign o_rsp.carry = w_full[ALU_W];
    assign o_rsp.zero  = (w_full[ALU_W-1:0] == '0);

endmodule

@@ design/operator_priority_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// operator_priority_scheduler_core
// priority engine over operator and pipeline cycle counts
// ----------------------------------------------------------------------------
// query on an active, unblocked slot: the result follows the slot walk and the
//   shift-add multiply, which both run through the single shared adder; no new
//   transfer is taken until the result has gone to the output register
// blocked or unknown query: result straight after the check; notice: no result
// synchronous active-low reset clears config, state, flags, operator counts and output valid, pipeline counts to one
module operator_priority_scheduler_core
    import ops_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_operation,
    input  logic [SLOT_W-1:0]        i_op_slot,
    input  logic                     i_was_back_pressured,
    input  logic                     i_ran_dry,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [PRIO_W-1:0]        o_priority_res,
    output logic [LEFT_W-1:0]        o_cycles_left,
    output logic                     o_pipeline_advanced,
    output logic                     o_unknown_slot
);

`include "assert_macros.svh"

    t_state r_state, n_state;

    logic [ADJ_W-1:0]      r_adj;
    logic [TOTALS_W-1:0]   r_totals;
    logic [PMAP_REG_W-1:0] r_pmap;
    logic [MASK_W-1:0]     r_active;
    logic [MASK_W-1:0]     r_source;

    logic [NUM_OPS-1:0]    r_blocked, n_blocked;
    logic [NUM_OPS-1:0]    r_starved, n_starved;
    logic [CYCLE_BITS-1:0] r_opc   [NUM_OPS];
    logic [CYCLE_BITS-1:0] r_pipec [NUM_PIPES];

    logic                  r_op;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_bp;
    logic                  r_dry;
    logic [PIPE_IDX_W-1:0] r_pipe;
    logic [CYCLE_BITS-1:0] r_pc;
    logic [CYCLE_BITS-1:0] r_cur_opc;
    logic                  r_complete;
    logic [OP_IDX_W-1:0]   r_idx;
    logic [LEFT_W-1:0]     r_left;
    logic [MULT_W-1:0]     r_mult;
    logic [MCNT_W-1:0]     r_mcnt;
    logic [PRIO_W-1:0]     r_acc;
    logic                  r_adv;
    logic                  r_unknown;

    logic                  r_out_valid;
    logic [PRIO_W-1:0]     r_out_prio;
    logic [LEFT_W-1:0]     r_out_left;
    logic                  r_out_adv;
    logic                  r_out_unknown;

    logic                  w_slot_ok;
    logic [OP_IDX_W-1:0]   w_slot_idx;
    logic                  w_active;
    logic                  w_flagged;
    logic [OP_IDX_W-1:0]   w_rd_idx;
    logic [CYCLE_BITS-1:0] w_rd_cnt;
    logic                  w_out_free;
    logic [PIPE_IDX_W-1:0] w_slot_pipe;
    logic [PIPE_IDX_W-1:0] w_walk_pipe;
    logic [PRIO_W-1:0]     w_shifted;
    logic                  w_in_xfer;
    t_alu_req              w_alu_req;
    t_alu_rsp              w_alu_rsp;

    function automatic logic [PIPE_IDX_W-1:0] pipe_of(input logic [SLOT_W-1:0] s);
        logic [PMAP_W-1:0] p;
        p = r_pmap[int'(s) * PMAP_W +: PMAP_W];
        if (int'(p) > NUM_PIPES - 1) begin
            p = PMAP_W'(NUM_PIPES - 1);
        end
        return PIPE_IDX_W'(p);
    endfunction

    function automatic logic [LEFT_W-1:0] sat_left(input logic [CYCLE_BITS-1:0] d);
        logic [SAT_W-1:0] t;
        t = SAT_W'(d);
        if (t > SAT_W'({LEFT_W{1'b1}})) begin
            return '1;
        end
        return t[LEFT_W-1:0];
    endfunction

    ops_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    assign w_slot_ok   = ({1'b0, r_slot} < (SLOT_W + 1)'(NUM_OPS));
    assign w_slot_idx  = r_slot[OP_IDX_W-1:0];
    assign w_active    = w_slot_ok && r_active[r_slot];
    assign w_flagged   = r_blocked[w_slot_idx] || r_starved[w_slot_idx];
    assign w_rd_idx    = (r_state == S_WALK) ? r_idx : w_slot_idx;
    assign w_rd_cnt    = r_opc[w_rd_idx];
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_slot_pipe = pipe_of(r_slot);
    assign w_walk_pipe = pipe_of(SLOT_W'(r_idx));
    assign w_shifted   = PRIO_W'(r_left) << r_mcnt;
    assign w_in_xfer   = i_in_valid && !o_in_stall;

    assign o_in_stall          = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_priority_res      = r_out_prio;
    assign o_cycles_left       = r_out_left;
    assign o_pipeline_advanced = r_out_adv;
    assign o_unknown_slot      = r_out_unknown;

    // flag update of a completion notice, back pressure first
    always_comb begin
        n_blocked = r_blocked;
        n_starved = r_starved;
        if (r_bp) begin
            n_blocked[w_slot_idx] = 1'b1;
            for (int i = 0; i < NUM_OPS; i++) begin
                if (r_adj[{r_slot, 3'(i)}]) begin
                    n_starved[i] = 1'b0;
                end
            end
        end
        if (r_dry && !r_source[r_slot]) begin
            n_starved[w_slot_idx] = 1'b1;
            for (int i = 0; i < NUM_OPS; i++) begin
                if (r_adj[{3'(i), r_slot}]) begin
                    n_blocked[i] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_op == OP_NOTIFY) begin
                    n_state = S_IDLE;
                end else if (!w_active || w_flagged) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_idx == OP_IDX_W'(NUM_OPS - 1)) begin
                    n_state = S_ADV;
                end
            end
            S_ADV: n_state = S_SUB;
            S_SUB: n_state = S_MUL;
            S_MUL: begin
                if (r_mcnt == MCNT_W'(MULT_W - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_alu_req = '0;
        unique case (r_state)
            S_CHECK: begin
                w_alu_req.a = ALU_W'(w_rd_cnt);
                w_alu_req.b = ALU_W'(1);
            end
            S_WALK: begin
                w_alu_req.a   = ALU_W'(r_pc);
                w_alu_req.b   = ALU_W'(w_rd_cnt);
                w_alu_req.sub = 1'b1;
            end
            S_ADV: begin
                w_alu_req.a = ALU_W'(r_pc);
                w_alu_req.b = ALU_W'(1);
            end
            S_SUB: begin
                w_alu_req.a   = ALU_W'(r_pc);
                w_alu_req.b   = ALU_W'(r_cur_opc);
                w_alu_req.sub = 1'b1;
            end
            S_MUL: begin
                w_alu_req.a = ALU_W'(r_acc);
                w_alu_req.b = ALU_W'(w_shifted);
            end
            default: w_alu_req = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj    <= '0;
            r_totals <= '0;
            r_pmap   <= '0;
            r_active <= '0;
            r_source <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ADJ:    r_adj    <= i_cfg_data[ADJ_W-1:0];
                CFG_TOTALS: r_totals <= i_cfg_data[TOTALS_W-1:0];
                CFG_PMAP:   r_pmap   <= i_cfg_data[PMAP_REG_W-1:0];
                CFG_ACTIVE: r_active <= i_cfg_data[MASK_W-1:0];
                CFG_SOURCE: r_source <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_blocked   <= '0;
            r_starved   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_OPS; i++) begin
                r_opc[i] <= '0;
            end
            for (int i = 0; i < NUM_PIPES; i++) begin
                r_pipec[i] <= CYCLE_BITS'(1);
            end
        end else begin
            r_state <= n_state;

            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_op   <= i_operation;
                        r_slot <= i_op_slot;
                        r_bp   <= i_was_back_pressured;
                        r_dry  <= i_ran_dry;
                    end
                end
                S_CHECK: begin
                    if (r_op == OP_NOTIFY) begin
                        if (w_active) begin
                            r_blocked         <= n_blocked;
                            r_starved         <= n_starved;
                            r_opc[w_slot_idx] <= w_alu_rsp.sum[CYCLE_BITS-1:0];
                        end
                    end else begin
                        r_unknown  <= !w_active;
                        r_acc      <= '0;
                        r_left     <= '0;
                        r_adv      <= 1'b0;
                        r_pipe     <= w_slot_pipe;
                        r_pc       <= r_pipec[w_slot_pipe];
                        r_complete <= 1'b1;
                        r_idx      <= '0;
                        r_mcnt     <= '0;
                        r_mult     <= MULT_W'(r_totals[int'(r_slot) * TOT_W +: TOT_W])
                                      + MULT_W'(1);
                    end
                end
                S_WALK: begin
                    if (r_active[r_idx] && (w_walk_pipe == r_pipe) && !w_alu_rsp.zero) begin
                        r_complete <= 1'b0;
                    end
                    if (r_idx == w_slot_idx) begin
                        r_cur_opc <= w_rd_cnt;
                    end
                    r_idx <= r_idx + OP_IDX_W'(1);
                end
                S_ADV: begin
                    if (r_complete) begin
                        r_pc            <= w_alu_rsp.sum[CYCLE_BITS-1:0];
                        r_pipec[r_pipe] <= w_alu_rsp.sum[CYCLE_BITS-1:0];
                        r_adv           <= 1'b1;
                    end
                end
                S_SUB: begin
                    r_left <= w_alu_rsp.carry ? sat_left(w_alu_rsp.sum[CYCLE_BITS-1:0])
                                              : '0;
                end
                S_MUL: begin
                    if (r_mult[r_mcnt]) begin
                        r_acc <= w_alu_rsp.sum[PRIO_W-1:0];
                    end
                    r_mcnt <= r_mcnt + MCNT_W'(1);
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_prio    <= r_acc;
                        r_out_left    <= r_left;
                        r_out_adv     <= r_adv;
                        r_out_unknown <= r_unknown;
                    end
                end
                default: ;
            endcase
        end
    end

    `ASSERT_NEVER(a_adv_unknown, o_out_valid && o_pipeline_advanced && o_unknown_slot, "advance on unknown slot")
    `ASSERT_IMPLY(a_unknown_zero, o_out_valid && o_unknown_slot, (o_priority_res == '0) && (o_cycles_left == '0), "unknown slot with nonzero result")
    `ASSERT_IMPLY(a_prio_left, o_out_valid, (o_priority_res == '0) == (o_cycles_left == '0), "priority and cycles left disagree on zero")
    `ASSERT_NEXT(a_notify_len, w_in_xfer && (i_operation == OP_NOTIFY), ##1 (r_state == S_IDLE), "notice did not finish in two cycles")

endmodule

@@ dv/tb_operator_priority_scheduler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_operator_priority_scheduler_core
// drives priority queries and completion notices into the scheduler core,
// tracks operator flags and cycle counts alongside it, and checks each
// priority result field by field, under random gaps and output stalls
// ----------------------------------------------------------------------------
module tb_operator_priority_scheduler_core;
    import ops_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 2 * NUM_OPS + 12;
    localparam int RESET_CYCLES  = 7;
    localparam int ADJ_ROW       = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int NUM_PHASES    = 8;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] slot;
        logic              back_pressured;
        logic              ran_dry;
    } t_sched_item;

    typedef struct packed {
        logic [PRIO_W-1:0] priority_res;
        logic [LEFT_W-1:0] cycles_left;
        logic              pipeline_advanced;
        logic              unknown_slot;
    } t_prio_result;

    logic                  i_clk                = 1'b0;
    logic                  i_rst_n              = 1'b0;
    logic                  i_cfg_we             = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index          = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data           = '0;
    logic                  i_in_valid           = 1'b0;
    logic                  o_in_stall;
    logic                  i_operation          = OP_QUERY;
    logic [SLOT_W-1:0]     i_op_slot            = '0;
    logic                  i_was_back_pressured = 1'b0;
    logic                  i_ran_dry            = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall          = 1'b0;
    logic [PRIO_W-1:0]     o_priority_res;
    logic [LEFT_W-1:0]     o_cycles_left;
    logic                  o_pipeline_advanced;
    logic                  o_unknown_slot;

    // scheduler state as the block should hold it
    logic [ADJ_W-1:0]      adjacency   = '0;
    logic [TOTALS_W-1:0]   down_totals = '0;
    logic [PMAP_REG_W-1:0] pipe_map    = '0;
    logic [MASK_W-1:0]     active_mask = '0;
    logic [MASK_W-1:0]     source_mask = '0;
    logic                  blocked    [NUM_OPS];
    logic                  starved    [NUM_OPS];
    logic [CYCLE_BITS-1:0] op_cycle   [NUM_OPS];
    logic [CYCLE_BITS-1:0] pipe_cycle [NUM_PIPES];

    t_sched_item  pending_ops [$];
    t_prio_result prio_expected [$];
    t_sched_item  cur_item   = '0;
    bit           in_taken   = 1'b0;
    bit           no_idle    = 1'b0;
    int unsigned  in_gap     = 0;
    int unsigned  stall_left = 0;
    int unsigned  run_left   = 0;
    int           fail_cnt   = 0;
    int           cycle_cnt  = 0;

    operator_priority_scheduler_core u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_operation          (i_operation),
        .i_op_slot            (i_op_slot),
        .i_was_back_pressured (i_was_back_pressured),
        .i_ran_dry            (i_ran_dry),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_priority_res       (o_priority_res),
        .o_cycles_left        (o_cycles_left),
        .o_pipeline_advanced  (o_pipeline_advanced),
        .o_unknown_slot       (o_unknown_slot)
    );

    initial begin : clock_gen
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit slot_on(input int s);
        return (s < NUM_OPS) && active_mask[s];
    endfunction

    function automatic int pipe_of(input int s);
        int p;
        p = int'(pipe_map[s*PMAP_W +: PMAP_W]);
        if (p >= NUM_PIPES) begin
            p = NUM_PIPES - 1;
        end
        return p;
    endfunction

    // updates the scheduler state for one transfer, returns 1 when a result follows
    function automatic bit predict_priority(input t_sched_item it, output t_prio_result res);
        int                    op;
        int                    p;
        logic [CYCLE_BITS-1:0] pc;
        logic [63:0]           left;
        logic [63:0]           weight;
        bit                    complete;
        op  = int'(it.slot);
        res = '0;
        if (it.operation == OP_NOTIFY) begin
            if (!slot_on(op)) return 1'b0;
            if (it.back_pressured) begin
                blocked[op] = 1'b1;
                for (int i = 0; i < NUM_OPS; i++) begin
                    if (adjacency[op*ADJ_ROW + i]) starved[i] = 1'b0;
                end
            end
            if (it.ran_dry && !source_mask[op]) begin
                starved[op] = 1'b1;
                for (int i = 0; i < NUM_OPS; i++) begin
                    if (adjacency[i*ADJ_ROW + op]) blocked[i] = 1'b0;
                end
            end
            op_cycle[op] = op_cycle[op] + 1'b1;
            return 1'b0;
        end
        if (!slot_on(op)) begin
            res.unknown_slot = 1'b1;
            return 1'b1;
        end
        if (blocked[op] || starved[op]) return 1'b1;
        p        = pipe_of(op);
        pc       = pipe_cycle[p];
        complete = 1'b1;
        for (int i = 0; i < NUM_OPS; i++) begin
            if (slot_on(i) && pipe_of(i) == p && op_cycle[i] != pc) complete = 1'b0;
        end
        if (complete) begin
            pc                    = pc + 1'b1;
            pipe_cycle[p]         = pc;
            res.pipeline_advanced = 1'b1;
        end
        left = (pc >= op_cycle[op]) ? 64'(pc - op_cycle[op]) : 64'd0;
        if (left > 64'hFFFF_FFFF) begin
            left = 64'hFFFF_FFFF;
        end
        weight           = 64'(down_totals[op*TOT_W +: TOT_W]) + 64'd1;
        res.cycles_left  = left[LEFT_W-1:0];
        res.priority_res = PRIO_W'(weight * left);
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [PRIO_W-1:0] want,
                                        input logic [PRIO_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    function automatic void push_item(input logic op, input int slot, input logic bp,
                                      input logic dry);
        pending_ops.push_back({op, SLOT_W'(slot), bp, dry});
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] adj, input logic [CFG_DATA_W-1:0] tot,
                               input logic [CFG_DATA_W-1:0] pmap,
                               input logic [CFG_DATA_W-1:0] act,
                               input logic [CFG_DATA_W-1:0] src);
        write_reg(CFG_ADJ, adj);
        write_reg(CFG_TOTALS, tot);
        write_reg(CFG_PMAP, pmap);
        write_reg(CFG_ACTIVE, act);
        write_reg(CFG_SOURCE, src);
    endtask

    task automatic drain_all();
        while (pending_ops.size() != 0 || i_in_valid || prio_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly full rounds that bring a pipeline's members up to its cycle, plus noise
    task automatic gen_traffic(input int n);
        int                    cnt;
        int                    p;
        int                    s;
        logic                  op;
        logic [CYCLE_BITS-1:0] diff;
        int                    members [$];
        cnt = 0;
        while (cnt < n) begin
            while (pending_ops.size() != 0 || i_in_valid) begin
                @(posedge i_clk);
            end
            if ($urandom_range(0, 99) < 60) begin
                p = $urandom_range(0, NUM_PIPES - 1);
                members.delete();
                for (int i = 0; i < NUM_OPS; i++) begin
                    if (slot_on(i) && pipe_of(i) == p) members.push_back(i);
                end
                foreach (members[k]) begin
                    diff = pipe_cycle[p] - op_cycle[members[k]];
                    if (op_cycle[members[k]] <= pipe_cycle[p] && diff <= 4) begin
                        repeat (diff) begin
                            push_item(OP_NOTIFY, members[k], $urandom_range(0, 11) == 0,
                                      $urandom_range(0, 11) == 0);
                            cnt++;
                        end
                    end
                end
                if (members.size() > 0) begin
                    if ($urandom_range(0, 15) == 0) begin
                        push_item(OP_NOTIFY, members[$urandom_range(0, members.size() - 1)],
                                  1'b0, 1'b0);
                        cnt++;
                    end
                    repeat ($urandom_range(1, 3)) begin
                        push_item(OP_QUERY, members[$urandom_range(0, members.size() - 1)],
                                  $urandom_range(0, 1), $urandom_range(0, 1));
                        cnt++;
                    end
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    op = ($urandom_range(0, 2) == 0) ? OP_NOTIFY : OP_QUERY;
                    s  = $urandom_range(0, 7);
                    push_item(op, s, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
                    if (!(op == OP_NOTIFY && !slot_on(s))) cnt++;
                end
            end
        end
    endtask

    always @(negedge i_clk) begin : feed
        t_sched_item nxt;
        logic        nxt_valid;
        nxt       = cur_item;
        nxt_valid = i_in_valid && !in_taken;
        if (i_rst_n && !nxt_valid) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (pending_ops.size() > 0) begin
                nxt       = pending_ops.pop_front();
                nxt_valid = 1'b1;
                in_gap    = no_idle ? 0 : pick_gap();
            end
        end
        cur_item              = nxt;
        i_in_valid           <= nxt_valid;
        i_operation          <= nxt.operation;
        i_op_slot            <= nxt.slot;
        i_was_back_pressured <= nxt.back_pressured;
        i_ran_dry            <= nxt.ran_dry;
    end

    always @(negedge i_clk) begin : sink_pace
        if (stall_left > 0) begin
            stall_left--;
        end else if (run_left > 0) begin
            run_left--;
        end else if (!no_idle) begin
            stall_left = pick_gap();
            run_left   = $urandom_range(0, 8);
        end
        i_out_stall <= (stall_left > 0);
    end

    always @(posedge i_clk) begin : monitor
        t_sched_item  item;
        t_prio_result got;
        t_prio_result want;
        item     = {i_operation, i_op_slot, i_was_back_pressured, i_ran_dry};
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            if (predict_priority(item, want)) prio_expected.push_back(want);
        end
        if (i_rst_n && i_cfg_we) begin
            case (i_cfg_index)
                CFG_ADJ:    adjacency   = i_cfg_data[ADJ_W-1:0];
                CFG_TOTALS: down_totals = i_cfg_data[TOTALS_W-1:0];
                CFG_PMAP:   pipe_map    = i_cfg_data[PMAP_REG_W-1:0];
                CFG_ACTIVE: active_mask = i_cfg_data[MASK_W-1:0];
                CFG_SOURCE: source_mask = i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_priority_res, o_cycles_left, o_pipeline_advanced, o_unknown_slot};
            if (prio_expected.size() == 0) begin
                $error("priority result transfer with nothing expected");
                fail_cnt++;
            end else begin
                want = prio_expected.pop_front();
                check_field("priority_res", want.priority_res, got.priority_res);
                check_field("cycles_left", want.cycles_left, got.cycles_left);
                check_field("pipeline_advanced", want.pipeline_advanced, got.pipeline_advanced);
                check_field("unknown_slot", want.unknown_slot, got.unknown_slot);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        foreach (blocked[i]) begin
            blocked[i]  = 1'b0;
            starved[i]  = 1'b0;
            op_cycle[i] = '0;
        end
        foreach (pipe_cycle[i]) begin
            pipe_cycle[i] = 1;
        end
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // nothing registered yet
        push_item(OP_QUERY, 0, 1'b0, 1'b0);
        push_item(OP_NOTIFY, 7, 1'b1, 1'b1);
        push_item(OP_QUERY, 7, 1'b1, 1'b1);
        push_item(OP_NOTIFY, 0, 1'b0, 1'b0);
        drain_all();

        // chains 0-1-2-3 and 0-7, 4-5, 6-7; slot 5 off; sources 0 and 4
        load_config(64'h0080_0020_0008_0482, 64'h04_1057, 64'hE500, 64'hDF, 64'h11);
        push_item(OP_QUERY, 0, 1'b0, 1'b0);
        for (int s = 0; s < 4; s++) begin
            push_item(OP_NOTIFY, s, 1'b0, 1'b0);
        end
        push_item(OP_QUERY, 1, 1'b0, 1'b0);
        push_item(OP_QUERY, 5, 1'b1, 1'b1);
        push_item(OP_NOTIFY, 5, 1'b1, 1'b1);
        push_item(OP_NOTIFY, 6, 1'b0, 1'b0);
        push_item(OP_NOTIFY, 6, 1'b0, 1'b0);
        push_item(OP_QUERY, 6, 1'b0, 1'b0);
        push_item(OP_NOTIFY, 1, 1'b1, 1'b0);
        push_item(OP_QUERY, 1, 1'b0, 1'b0);
        push_item(OP_NOTIFY, 2, 1'b0, 1'b1);
        push_item(OP_QUERY, 2, 1'b0, 1'b0);
        push_item(OP_QUERY, 1, 1'b0, 1'b0);
        push_item(OP_NOTIFY, 0, 1'b1, 1'b1);
        push_item(OP_QUERY, 0, 1'b0, 1'b0);
        push_item(OP_NOTIFY, 3, 1'b1, 1'b1);
        push_item(OP_QUERY, 3, 1'b0, 1'b0);
        push_item(OP_NOTIFY, 1, 1'b1, 1'b1);
        push_item(OP_QUERY, 0, 1'b0, 1'b0);
        push_item(OP_QUERY, 2, 1'b0, 1'b0);
        push_item(OP_QUERY, 7, 1'b0, 1'b0);
        drain_all();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            no_idle = (ph == 2 || ph == 5);
            case (ph)
                0:       load_config('0, '0, '0, 64'hFF, '0);
                1:       load_config('1, '1, '1, '1, '1);
                default: load_config(rand64(), rand64(), rand64(), rand64() | rand64(),
                                     rand64());
            endcase
            if (ph % 3 == 0) begin
                write_reg(CFG_IDX_W'(CFG_SOURCE + 1 + $urandom_range(0, 2)), rand64());
            end
            gen_traffic(PHASE_ITEMS);
            drain_all();
        end

        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
